FILE: sv/mips_subset_execute_step_core_assert.svh
// assertion macros for the mips subset core
`ifndef MIPS_SUBSET_EXECUTE_STEP_CORE_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_STEP_CORE_ASSERT_SVH
`ifndef SYNTH
`define MSEC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSEC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MSEC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSEC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: sv/msec_pkg.sv
// shared types and instruction codes for the mips subset core
package msec_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;

  typedef enum logic [5:0] {
    OP_RTYPE = 6'b000000,
    OP_J     = 6'b000010,
    OP_JAL   = 6'b000011,
    OP_BEQ   = 6'b000100,
    OP_BNE   = 6'b000101,
    OP_ADDI  = 6'b001000,
    OP_ADDIU = 6'b001001,
    OP_SLTI  = 6'b001010,
    OP_SLTIU = 6'b001011,
    OP_ANDI  = 6'b001100,
    OP_ORI   = 6'b001101,
    OP_XORI  = 6'b001110,
    OP_LW    = 6'b100011,
    OP_SW    = 6'b101011
  } opcode_e;

  typedef enum logic [5:0] {
    FN_SLL  = 6'b000000,
    FN_SRL  = 6'b000010,
    FN_SRA  = 6'b000011,
    FN_SLLV = 6'b000100,
    FN_SRLV = 6'b000110,
    FN_SRAV = 6'b000111,
    FN_JR   = 6'b001000,
    FN_ADD  = 6'b100000,
    FN_ADDU = 6'b100001,
    FN_SUB  = 6'b100010,
    FN_SUBU = 6'b100011,
    FN_AND  = 6'b100100,
    FN_OR   = 6'b100101,
    FN_XOR  = 6'b100110,
    FN_NOR  = 6'b100111,
    FN_SLT  = 6'b101010,
    FN_SLTU = 6'b101011
  } funct_e;

  localparam reg_idx_t REG_SP = 5'd29;
  localparam reg_idx_t REG_RA = 5'd31;

  typedef struct packed {
    word_t    next_pc;
    logic     reg_write_valid;
    reg_idx_t reg_write_index;
    word_t    reg_write_value;
    logic     mem_write_valid;
    logic [11:0] mem_write_address;
    word_t    mem_write_word;
    logic     unknown_instruction;
  } result_t;

endpackage

FILE: sv/msec_instr_if.sv
// instruction channel
interface msec_instr_if import msec_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t instr;

  modport source (output valid, output instr, input ready);
  modport sink (input valid, input instr, output ready);
endinterface

FILE: sv/msec_result_if.sv
// result channel
interface msec_result_if import msec_pkg::*; ();
  logic        valid;
  logic        ready;
  word_t       next_pc;
  logic        reg_write_valid;
  reg_idx_t    reg_write_index;
  word_t       reg_write_value;
  logic        mem_write_valid;
  logic [11:0] mem_write_address;
  word_t       mem_write_word;
  logic        unknown_instruction;

  modport source (output valid, output next_pc, output reg_write_valid,
                  output reg_write_index, output reg_write_value,
                  output mem_write_valid, output mem_write_address,
                  output mem_write_word, output unknown_instruction, input ready);
  modport sink (input valid, input next_pc, input reg_write_valid,
                input reg_write_index, input reg_write_value,
                input mem_write_valid, input mem_write_address,
                input mem_write_word, input unknown_instruction, output ready);
endinterface

FILE: sv/mips_subset_execute_step_core.sv
// mips32 integer subset core, one instruction word in, one retirement record out
`include "mips_subset_execute_step_core_assert.svh"
// One instruction is taken per clock unless a load-use hazard, back-pressure or the
// clearing pass holds the input; one retirement record per instruction leaves through
// the stage 1, stage 2 and output registers. The register file (32 words, two
// synchronous read ports) is read at the accept edge; the byte-wide data memory sits
// in four banks of MEM_BYTES/4 rows so any unaligned, wrapping word is one access. An
// instruction using the target of the load just ahead waits in stage 1 until the load
// leaves stage 2, as load data only returns in the cycle after the address add. After
// reset the data memory is cleared one row per cycle, before the first accept.
module mips_subset_execute_step_core import msec_pkg::*; #(
  parameter int MEM_BYTES = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  msec_instr_if.sink    in_i,
  msec_result_if.source res_o
);

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam int ROWS   = MEM_BYTES / 4;
  localparam int ROW_W  = ADDR_W - 2;

  // pipeline control
  logic s1_v_q, s2_v_q, o_v_q;
  logic o_en, s2_en, s1_go, hazard, accept;

  // clearing pass
  logic             clr_q;
  logic [ROW_W-1:0] clr_cnt_q;

  // register file
  word_t      rf_q [32];
  logic [31:0] rf_valid_q;
  word_t      rda_q, rdb_q;
  logic       rf_we;
  reg_idx_t   rf_wa;
  word_t      rf_wd;

  // stage 1: execute
  word_t instr_q, pc_q;

  // stage 2: memory return
  word_t       s2_npc_q, s2_wval_q, s2_mword_q;
  logic        s2_wr_q, s2_mw_q, s2_unk_q, s2_ld_q;
  reg_idx_t    s2_widx_q;
  logic [11:0] s2_maddr_q;
  logic [1:0]  s2_lo_q;
  logic [7:0]  rdata_q [4];
  word_t       s2_value;

  result_t o_q;

  // handshakes: a stage advances when the next is free or moving (stage 1: and no hazard)
  assign o_en   = !o_v_q || res_o.ready;
  assign s2_en  = !s2_v_q || o_en;
  assign s1_go  = s1_v_q && s2_en && !hazard;
  assign in_i.ready = !clr_q && (!s1_v_q || s1_go);
  assign accept = in_i.valid && in_i.ready;

  // instruction fields
  opcode_e  opc;
  funct_e   fn;
  reg_idx_t rs, rt, rd;
  logic [4:0] sa;
  word_t    zimm, simm;
  assign opc  = opcode_e'(instr_q[31:26]);
  assign fn   = funct_e'(instr_q[5:0]);
  assign rs   = instr_q[25:21];
  assign rt   = instr_q[20:16];
  assign rd   = instr_q[15:11];
  assign sa   = instr_q[10:6];
  assign zimm = {16'h0000, instr_q[15:0]};
  assign simm = {{16{instr_q[15]}}, instr_q[15:0]};

  // load-use: a load still in stage 2 has no data yet for stage 1
  assign hazard = s1_v_q && s2_v_q && s2_ld_q && s2_wr_q &&
                  (s2_widx_q == rs || s2_widx_q == rt);

  // operands: the operand registers track every completed write, so only the
  // item in stage 2 can be newer
  word_t a, b;
  always_comb begin
    a = rda_q;
    b = rdb_q;
    if (s2_v_q && s2_wr_q && s2_widx_q == rs) begin
      a = s2_wval_q;
    end
    if (s2_v_q && s2_wr_q && s2_widx_q == rt) begin
      b = s2_wval_q;
    end
  end

  // execute
  word_t      pc4, ea, wval, npc;
  logic       wr, mw, unk, ld;
  reg_idx_t   widx;
  logic [ADDR_W-1:0] maddr;
  always_comb begin
    pc4  = pc_q + 32'd4;
    ea   = a + simm;
    npc  = pc4;
    wr   = 1'b0;
    widx = rt;
    wval = '0;
    mw   = 1'b0;
    unk  = 1'b0;
    ld   = 1'b0;
    unique case (opc)
      OP_RTYPE: begin
        wr   = 1'b1;
        widx = rd;
        unique case (fn)
          FN_ADD, FN_ADDU: wval = a + b;
          FN_SUB, FN_SUBU: wval = a - b;
          FN_AND:  wval = a & b;
          FN_OR:   wval = a | b;
          FN_XOR:  wval = a ^ b;
          FN_NOR:  wval = ~(a | b);
          FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
          FN_SLTU: wval = {31'd0, a < b};
          FN_SLL:  wval = b << sa;
          FN_SRL:  wval = b >> sa;
          FN_SRA:  wval = word_t'($signed(b) >>> sa);
          FN_SLLV: wval = b << a[4:0];
          FN_SRLV: wval = b >> a[4:0];
          FN_SRAV: wval = word_t'($signed(b) >>> a[4:0]);
          FN_JR: begin
            wr  = 1'b0;
            npc = a;
          end
          default: begin
            wr  = 1'b0;
            unk = 1'b1;
          end
        endcase
      end
      OP_ADDI, OP_ADDIU: begin
        wr   = 1'b1;
        wval = ea;
      end
      OP_ANDI: begin
        wr   = 1'b1;
        wval = a & zimm;
      end
      OP_ORI: begin
        wr   = 1'b1;
        wval = a | zimm;
      end
      OP_XORI: begin
        wr   = 1'b1;
        wval = a ^ zimm;
      end
      OP_SLTI: begin
        wr   = 1'b1;
        wval = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin
        wr   = 1'b1;
        wval = {31'd0, a < simm};
      end
      OP_LW: begin
        wr = 1'b1;
        ld = 1'b1;
      end
      OP_SW: mw = 1'b1;
      OP_BEQ: begin
        if (a == b) begin
          npc = pc4 + {simm[29:0], 2'b00};
        end
      end
      OP_BNE: begin
        if (a != b) begin
          npc = pc4 + {simm[29:0], 2'b00};
        end
      end
      OP_J: npc = {pc4[31:28], instr_q[25:0], 2'b00};
      OP_JAL: begin
        npc  = {pc4[31:28], instr_q[25:0], 2'b00};
        wr   = 1'b1;
        widx = REG_RA;
        wval = pc4;
      end
      default: unk = 1'b1;
    endcase
    // r0 stays zero
    if (!wr || widx == '0) begin
      wr   = 1'b0;
      widx = '0;
      wval = '0;
    end
    maddr = ea[ADDR_W-1:0];
  end

  // stage 1 valid, instruction and program counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        pc_q <= npc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= in_i.instr;
    end
  end

  // register file: written when a record leaves stage 2
  assign rf_we = s2_v_q && o_en && s2_wr_q;
  assign rf_wa = s2_widx_q;
  assign rf_wd = s2_value;

  function automatic word_t rf_reset_val(reg_idx_t idx);
    rf_reset_val = (idx == REG_SP) ? word_t'(MEM_BYTES) : '0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[rf_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
  end

  // read ports with write-first bypass; while waiting in stage 1 the operand
  // registers pick up any write to the same register
  reg_idx_t in_rs, in_rt;
  assign in_rs = in_i.instr[25:21];
  assign in_rt = in_i.instr[20:16];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (rf_we && rf_wa == in_rs) begin
        rda_q <= rf_wd;
      end else begin
        rda_q <= rf_valid_q[in_rs] ? rf_q[in_rs] : rf_reset_val(in_rs);
      end
      if (rf_we && rf_wa == in_rt) begin
        rdb_q <= rf_wd;
      end else begin
        rdb_q <= rf_valid_q[in_rt] ? rf_q[in_rt] : rf_reset_val(in_rt);
      end
    end else begin
      if (rf_we && rf_wa == rs) begin
        rda_q <= rf_wd;
      end
      if (rf_we && rf_wa == rt) begin
        rdb_q <= rf_wd;
      end
    end
  end

  // clearing pass over the data memory rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ROW_W'(ROWS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // data memory: four byte banks, bank j holds byte addresses with low bits j
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]        mem_q [ROWS];
    logic [1:0]        off;
    logic [ADDR_W-1:0] baddr;
    logic [ROW_W-1:0]  row;
    logic [7:0]        sbyte;

    assign off   = 2'(j) - maddr[1:0];
    assign baddr = maddr + ADDR_W'(off);
    assign row   = baddr[ADDR_W-1:2];
    assign sbyte = 8'(b >> {2'd3 - off, 3'b000});

    always_ff @(posedge clk_i) begin
      if (clr_q) begin
        mem_q[clr_cnt_q] <= '0;
      end else if (s1_go && mw) begin
        mem_q[row] <= sbyte;
      end
    end

    always_ff @(posedge clk_i) begin
      if (s1_go) begin
        rdata_q[j] <= mem_q[row];
      end
    end
  end

  // stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_npc_q   <= npc;
      s2_wr_q    <= wr;
      s2_widx_q  <= widx;
      s2_wval_q  <= wval;
      s2_mw_q    <= mw;
      s2_maddr_q <= mw ? 12'(32'(maddr)) : '0;
      s2_mword_q <= mw ? b : '0;
      s2_unk_q   <= unk;
      s2_ld_q    <= ld;
      s2_lo_q    <= maddr[1:0];
    end
  end

  // load word assembly, most significant byte from the lowest address
  always_comb begin
    s2_value = s2_wval_q;
    if (s2_ld_q && s2_wr_q) begin
      s2_value = {rdata_q[s2_lo_q], rdata_q[s2_lo_q + 2'd1],
                  rdata_q[s2_lo_q + 2'd2], rdata_q[s2_lo_q + 2'd3]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_en) begin
      o_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_en && s2_v_q) begin
      o_q.next_pc             <= s2_npc_q;
      o_q.reg_write_valid     <= s2_wr_q;
      o_q.reg_write_index     <= s2_widx_q;
      o_q.reg_write_value     <= s2_value;
      o_q.mem_write_valid     <= s2_mw_q;
      o_q.mem_write_address   <= s2_maddr_q;
      o_q.mem_write_word      <= s2_mword_q;
      o_q.unknown_instruction <= s2_unk_q;
    end
  end

  assign res_o.valid               = o_v_q;
  assign res_o.next_pc             = o_q.next_pc;
  assign res_o.reg_write_valid     = o_q.reg_write_valid;
  assign res_o.reg_write_index     = o_q.reg_write_index;
  assign res_o.reg_write_value     = o_q.reg_write_value;
  assign res_o.mem_write_valid     = o_q.mem_write_valid;
  assign res_o.mem_write_address   = o_q.mem_write_address;
  assign res_o.mem_write_word      = o_q.mem_write_word;
  assign res_o.unknown_instruction = o_q.unknown_instruction;

  // checks
  `MSEC_ASSERT(a_no_r0_write, clk_i, rst_ni, rf_we |-> rf_wa != '0, "write to r0")
  `MSEC_ASSERT(a_no_exec_in_clear, clk_i, rst_ni, clr_q |-> !s1_go, "execute during clear")
  `MSEC_ASSERT_NEXT(a_clear_once, clk_i, rst_ni, !clr_q, !clr_q, "clear pass restarted")
  `MSEC_ASSERT_NEXT(a_pc_hold, clk_i, rst_ni, !s1_go, $stable(pc_q), "pc moved without execute")
  `MSEC_ASSERT_NEXT(a_hazard_holds, clk_i, rst_ni, hazard && o_en, s1_v_q && !s2_v_q, "load-use bubble lost")

endmodule

FILE: tb/sv/tb_mips_subset_execute_step_core.sv
// testbench for the mips subset core: directed program table then random instruction mix
module tb_mips_subset_execute_step_core;
  import msec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_SIZE     = 4096;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  msec_instr_if  in_if ();
  msec_result_if res_if ();

  mips_subset_execute_step_core #(.MEM_BYTES(MEM_SIZE)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  // architectural state mirror
  word_t    arch_regs [32];
  logic [7:0] arch_mem [MEM_SIZE];
  word_t    arch_pc;

  result_t retire_queue [$];
  int      fail_count;
  int      cycle_count;
  bit      calm;

  initial begin
    clk_i = 1'b0;
    forever begin
      #6 clk_i = 1'b1;
      #6 clk_i = 1'b0;
    end
  end

  // hard stop if the core hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t enc_r(funct_e fn, reg_idx_t rs, reg_idx_t rt, reg_idx_t rd,
                                  logic [4:0] sa);
    return {OP_RTYPE, rs, rt, rd, sa, fn};
  endfunction

  function automatic word_t enc_i(opcode_e op, reg_idx_t rs, reg_idx_t rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic word_t enc_j(opcode_e op, logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // execute one instruction on the mirror state and return its retirement record
  function automatic result_t execute_instr(word_t ins);
    result_t    r;
    reg_idx_t   rs, rt, rd;
    logic [4:0] sa;
    word_t      a, b, zimm, simm, pc4, ea;
    logic       wr, mw, unk;
    reg_idx_t   widx;
    word_t      wval;
    rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sa = ins[10:6];
    zimm = {16'h0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = arch_regs[rs]; b = arch_regs[rt];
    pc4 = arch_pc + 32'd4;
    ea = a + simm;
    r = '0;
    r.next_pc = pc4;
    wr = 1'b1; mw = 1'b0; unk = 1'b0; wval = '0;
    if (ins[31:26] == OP_RTYPE) begin
      widx = rd;
      case (ins[5:0])
        FN_ADD, FN_ADDU: wval = a + b;
        FN_SUB, FN_SUBU: wval = a - b;
        FN_AND:  wval = a & b;
        FN_OR:   wval = a | b;
        FN_XOR:  wval = a ^ b;
        FN_NOR:  wval = ~(a | b);
        FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: wval = {31'd0, a < b};
        FN_SLL:  wval = b << sa;
        FN_SRL:  wval = b >> sa;
        FN_SRA:  wval = $signed(b) >>> sa;
        FN_SLLV: wval = b << a[4:0];
        FN_SRLV: wval = b >> a[4:0];
        FN_SRAV: wval = $signed(b) >>> a[4:0];
        FN_JR: begin
          wr = 1'b0;
          r.next_pc = a;
        end
        default: begin
          wr = 1'b0;
          unk = 1'b1;
        end
      endcase
    end else begin
      widx = rt;
      case (ins[31:26])
        OP_ADDI, OP_ADDIU: wval = a + simm;
        OP_ANDI:  wval = a & zimm;
        OP_ORI:   wval = a | zimm;
        OP_XORI:  wval = a ^ zimm;
        OP_SLTI:  wval = {31'd0, $signed(a) < $signed(simm)};
        OP_SLTIU: wval = {31'd0, a < simm};
        OP_LW: begin
          // big-endian, every byte wraps on its own
          for (int i = 0; i < 4; i++)
            wval = {wval[23:0], arch_mem[(ea + i) % MEM_SIZE]};
        end
        OP_SW: begin
          wr = 1'b0;
          mw = 1'b1;
          r.mem_write_address = 12'((ea) % MEM_SIZE);
          r.mem_write_word = b;
          for (int i = 0; i < 4; i++)
            arch_mem[(ea + i) % MEM_SIZE] = b[31 - 8 * i -: 8];
        end
        OP_BEQ: begin
          wr = 1'b0;
          if (a == b) r.next_pc = pc4 + (simm << 2);
        end
        OP_BNE: begin
          wr = 1'b0;
          if (a != b) r.next_pc = pc4 + (simm << 2);
        end
        OP_J, OP_JAL: begin
          r.next_pc = {pc4[31:28], ins[25:0], 2'b00};
          if (ins[31:26] == OP_JAL) begin
            widx = REG_RA;
            wval = pc4;
          end else begin
            wr = 1'b0;
          end
        end
        default: begin
          wr = 1'b0;
          unk = 1'b1;
        end
      endcase
    end
    // r0 stays zero
    if (wr && widx == 5'd0) wr = 1'b0;
    if (wr) begin
      arch_regs[widx] = wval;
      r.reg_write_index = widx;
      r.reg_write_value = wval;
    end
    r.reg_write_valid = wr;
    r.mem_write_valid = mw;
    if (mw) r.mem_write_word = b;
    r.unknown_instruction = unk;
    arch_pc = r.next_pc;
    return r;
  endfunction

  // directed program: hand-written records where they are obvious
  typedef struct {
    word_t   instr;
    bit      typed;
    result_t rec;
  } stim_row_t;

  stim_row_t program_rows [$];

  function automatic result_t rec_of(word_t pc, logic wv, reg_idx_t wi, word_t val,
                                     logic unk);
    result_t r;
    r = '0;
    r.next_pc = pc;
    r.reg_write_valid = wv;
    r.reg_write_index = wi;
    r.reg_write_value = val;
    r.unknown_instruction = unk;
    return r;
  endfunction

  function automatic void add_row(word_t ins);
    stim_row_t s;
    s.instr = ins;
    s.typed = 1'b0;
    s.rec = '0;
    program_rows.insert(program_rows.size(), s);
  endfunction

  function automatic void add_typed(word_t ins, result_t rec);
    stim_row_t s;
    s.instr = ins;
    s.typed = 1'b1;
    s.rec = rec;
    program_rows.insert(program_rows.size(), s);
  endfunction

  task automatic build_program();
    // all-zero word is sll r0, discarded write
    add_typed(32'h0000_0000, rec_of(32'd4, 1'b0, 5'd0, 32'd0, 1'b0));
    // all-ones word has an unimplemented opcode
    add_typed(32'hFFFF_FFFF, rec_of(32'd8, 1'b0, 5'd0, 32'd0, 1'b1));
    add_typed(enc_i(OP_ADDIU, 5'd0, 5'd1, 16'hFFFF),
              rec_of(32'd12, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0));
    // unknown function code
    add_typed({OP_RTYPE, 20'h00000, 6'b000001}, rec_of(32'd16, 1'b0, 5'd0, 32'd0, 1'b1));
    add_row(enc_i(OP_ORI, 5'd0, 5'd2, 16'h8000));   // zero-extended immediate
    add_row(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
    add_row(enc_r(FN_ADD, 5'd1, 5'd3, 5'd4, 5'd0));
    add_row(enc_r(FN_SUB, 5'd0, 5'd1, 5'd5, 5'd0));
    add_row(enc_r(FN_NOR, 5'd2, 5'd3, 5'd6, 5'd0));
    add_row(enc_r(FN_SLT, 5'd1, 5'd0, 5'd7, 5'd0));
    add_row(enc_r(FN_SLTU, 5'd1, 5'd0, 5'd8, 5'd0));
    add_row(enc_r(FN_SLL, 5'd0, 5'd1, 5'd9, 5'd31));
    add_row(enc_r(FN_SRA, 5'd0, 5'd9, 5'd10, 5'd31));
    add_row(enc_r(FN_SRLV, 5'd1, 5'd1, 5'd11, 5'd0)); // shift amount masked to 5 bits
    add_row(enc_i(OP_SLTIU, 5'd0, 5'd12, 16'hFFFF)); // unsigned vs sign-extended
    add_row(enc_i(OP_XORI, 5'd1, 5'd13, 16'hFFFF));
    add_row(enc_i(OP_ADDIU, 5'd1, 5'd0, 16'h1234)); // write to r0 dropped
    add_row(enc_i(OP_SW, 5'd0, 5'd1, 16'hFFFE));     // wraps past the top of memory
    add_row(enc_i(OP_SW, 5'd29, 5'd4, 16'h0001));    // unaligned
    add_row(enc_i(OP_LW, 5'd0, 5'd14, 16'hFFFF));
    add_row(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h8000));
    add_row(enc_i(OP_BNE, 5'd1, 5'd0, 16'h7FFF));
    add_row(enc_j(OP_JAL, 26'h3FF_FFFF));
    add_row(enc_r(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0));
    add_row(enc_j(OP_J, 26'h000_0000));
  endtask

  // random word: mostly implemented instructions, a few raw words
  function automatic word_t random_instr();
    opcode_e op_list [14];
    funct_e  fn_list [17];
    word_t   w;
    int      k;
    op_list = '{OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI,
                OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LW, OP_SW};
    fn_list = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_ADD, FN_ADDU,
                FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    w = $urandom();
    k = $urandom_range(0, 99);
    if (k < 8) return w;
    if (k < 45) begin
      w[31:26] = OP_RTYPE;
      w[5:0] = fn_list[$urandom_range(0, 16)];
    end else if (k < 70) begin
      // loads and stores mostly near base r0 or sp, so they hit written bytes
      w[31:26] = ($urandom_range(0, 1) != 0) ? OP_LW : OP_SW;
      if ($urandom_range(0, 3) != 0) begin
        w[25:21] = ($urandom_range(0, 1) != 0) ? 5'd0 : REG_SP;
        w[15:0] = 16'($signed($urandom_range(0, 80)) - 40);
      end
    end else begin
      w[31:26] = op_list[$urandom_range(1, 11)];
    end
    return w;
  endfunction

  task automatic send_instr(word_t ins, bit typed, result_t rec);
    int gap;
    result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.instr <= ins;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = execute_instr(ins);
    retire_queue.insert(retire_queue.size(), typed ? rec : predicted);
  endtask

  task automatic wait_drained();
    while (retire_queue.size() != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    result_t none;
    none = '0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.instr = '0;
    calm = 1'b0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    arch_regs[REG_SP] = word_t'(MEM_SIZE);
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_pc = '0;
    build_program();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (program_rows[i]) send_instr(program_rows[i].instr, program_rows[i].typed,
                                         program_rows[i].rec);
    // sender holds off until the core has retired everything
    in_if.valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      send_instr(random_instr(), 1'b0, none);
    end
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && retire_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver back-pressure: random stalls, short mostly
  int stall_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // retirement checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (retire_queue.size() == 0) begin
        $error("retirement record with no instruction outstanding");
        fail_count++;
      end else begin
        want = retire_queue.pop_front();
        check_field("next_pc", want.next_pc, res_if.next_pc);
        check_field("reg_write_valid", want.reg_write_valid, res_if.reg_write_valid);
        check_field("reg_write_index", want.reg_write_index, res_if.reg_write_index);
        check_field("reg_write_value", want.reg_write_value, res_if.reg_write_value);
        check_field("mem_write_valid", want.mem_write_valid, res_if.mem_write_valid);
        check_field("mem_write_address", want.mem_write_address, res_if.mem_write_address);
        check_field("mem_write_word", want.mem_write_word, res_if.mem_write_word);
        check_field("unknown_instruction", want.unknown_instruction,
                    res_if.unknown_instruction);
      end
    end
  end

endmodule
